// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Field widths, controller states and the command/status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;

	localparam int HANDLE_W = 32;
	localparam int PRIO_W   = 32;
	localparam int COUNT_W  = 6;

	localparam int IN_TDATA_W  = HANDLE_W + PRIO_W;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 1 + HANDLE_W + COUNT_W + 1;

	// operation code carried in s_axis_tuser
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SRCH_CHK,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SH_CHK,
		ST_SH_RD,
		ST_SH_WR,
		ST_INSERT,
		ST_POP_RD,
		ST_POP_TAKE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;     // capture the input transfer
		logic init_search; // lo = 0, hi = count
		logic init_shift;  // idx = count
		logic rd_mid;      // read entry at search midpoint
		logic cmp_step;    // narrow the search window
		logic rd_shift;    // read entry idx-1
		logic wr_shift;    // write that entry to idx
		logic insert;      // write the new entry at the slot
		logic rd_front;    // read the front entry
		logic take_front;  // retire the front entry
		logic load_out;    // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic handle_zero;
		logic full;
		logic empty;
		logic search_more;
		logic shift_more;
		logic out_free;
	} sts_t;

endpackage

// ----- hdl/spq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: operation sequencer
// Steps a push through the binary search, the tail shift and the insert, and
// a pop through the front read, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);
	import spq_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.is_pop) begin
					state_nxt = sts.empty ? ST_FINISH : ST_POP_RD;
				end else begin
					state_nxt = (sts.handle_zero || sts.full) ? ST_FINISH : ST_SRCH_CHK;
				end
			end
			ST_SRCH_CHK: state_nxt = sts.search_more ? ST_SRCH_RD : ST_SH_CHK;
			ST_SRCH_RD:  state_nxt = ST_SRCH_CMP;
			ST_SRCH_CMP: state_nxt = ST_SRCH_CHK;
			ST_SH_CHK:   state_nxt = sts.shift_more ? ST_SH_RD : ST_INSERT;
			ST_SH_RD:    state_nxt = ST_SH_WR;
			ST_SH_WR:    state_nxt = ST_SH_CHK;
			ST_INSERT:   state_nxt = ST_FINISH;
			ST_POP_RD:   state_nxt = ST_POP_TAKE;
			ST_POP_TAKE: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_DECIDE:   cmd.init_search = 1'b1;
			ST_SRCH_CHK: cmd.init_shift = !sts.search_more;
			ST_SRCH_RD:  cmd.rd_mid = 1'b1;
			ST_SRCH_CMP: cmd.cmp_step = 1'b1;
			ST_SH_CHK:   cmd = '0;
			ST_SH_RD:    cmd.rd_shift = 1'b1;
			ST_SH_WR:    cmd.wr_shift = 1'b1;
			ST_INSERT:   cmd.insert = 1'b1;
			ST_POP_RD:   cmd.rd_front = 1'b1;
			ST_POP_TAKE: cmd.take_front = 1'b1;
			ST_FINISH:   cmd.load_out = sts.out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

// ----- hdl/spq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: entry store, search and shift registers, output stage
// Entries live in a circular memory; logical index 0 sits at the head, so a
// pop only advances the head while a push shifts the tail up by one.
// ----------------------------------------------------------------------------
module spq_datapath #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::cmd_t                    cmd,
	output spq_pkg::sts_t                    sts,
	input  logic [spq_pkg::IN_TDATA_W-1:0]   in_data,
	input  logic [spq_pkg::IN_TUSER_W-1:0]   in_user,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [spq_pkg::OUT_TDATA_W-1:0]  out_data
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int EW = HANDLE_W + PRIO_W;

	// input capture
	logic                op_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [PRIO_W-1:0]   prio_q;

	// queue control
	logic [CW-1:0] count_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] idx_q;

	// result and output stage
	logic                   res_ok_q;
	logic [HANDLE_W-1:0]    res_handle_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// entry store, {handle, priority}
	logic [EW-1:0] mem_q [QUEUE_DEPTH];
	logic [EW-1:0] rdata_q;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [EW-1:0] wr_data;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid;
	logic [CW-1:0] idx_dec;
	logic [CW+5:0] count_ext;

	// logical index -> physical address, relative to the head
	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [CW:0] s;
		s = (CW+1)'(head) + {1'b0, l};
		if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CW:1];
	assign idx_dec = idx_q - CW'(1);

	always_comb begin
		rd_en   = cmd.rd_mid | cmd.rd_shift | cmd.rd_front;
		rd_addr = head_q;
		if (cmd.rd_mid) begin
			rd_addr = wrap(head_q, mid);
		end else if (cmd.rd_shift) begin
			rd_addr = wrap(head_q, idx_dec);
		end
	end

	always_comb begin
		wr_en   = cmd.wr_shift | cmd.insert;
		wr_addr = wrap(head_q, idx_q);
		wr_data = rdata_q;
		if (cmd.insert) begin
			wr_addr = wrap(head_q, lo_q);
			wr_data = {handle_q, prio_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_user[0];
			handle_q <= in_data[HANDLE_W-1:0];
			prio_q   <= in_data[IN_TDATA_W-1:HANDLE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			head_q       <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			idx_q        <= '0;
			res_ok_q     <= 1'b0;
			res_handle_q <= '0;
		end else begin
			if (cmd.load_in) begin
				res_ok_q     <= 1'b0;
				res_handle_q <= '0;
			end
			if (cmd.init_search) begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			if (cmd.cmp_step) begin
				// stored priority >= new one: the slot lies after mid
				if ($signed(rdata_q[PRIO_W-1:0]) >= $signed(prio_q)) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			if (cmd.init_shift) idx_q <= count_q;
			if (cmd.wr_shift) idx_q <= idx_dec;
			if (cmd.insert) begin
				count_q  <= count_q + CW'(1);
				res_ok_q <= 1'b1;
			end
			if (cmd.take_front) begin
				res_handle_q <= rdata_q[EW-1:PRIO_W];
				res_ok_q     <= 1'b1;
				count_q      <= count_q - CW'(1);
				head_q       <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
			end
		end
	end

	assign count_ext = {6'd0, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {(count_q == '0), count_ext[COUNT_W-1:0], res_handle_q, res_ok_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign sts.is_pop      = (op_q == FUNC_POP);
	assign sts.handle_zero = (handle_q == '0);
	assign sts.full        = (count_q == CW'(QUEUE_DEPTH));
	assign sts.empty       = (count_q == '0);
	assign sts.search_more = (lo_q < hi_q);
	assign sts.shift_more  = (idx_q > lo_q);
	assign sts.out_free    = !out_valid_q || out_ready;

endmodule

// ----- hdl/stable_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted-array priority queue of message handles
// A push files a handle after every stored entry of equal or higher priority;
// a pop returns the front handle. One result per operation.
// ----------------------------------------------------------------------------
// One operation at a time. A rejected push or a pop of an empty queue goes
// straight to the result; a pop reads the front entry and retires it. A push
// runs S binary search probes, where S is at most ceil(log2(count+1)), with
// one memory read and compare each, then moves the M entries that sit behind
// the new one up by one slot (one read and one write each) and writes it.
// The next input transfer is taken the cycle after the result enters the
// output register, even while that result still waits on m_axis_tready. Null
// pushes and pushes into a full queue are rejected with accepted low.
module stable_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [spq_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // message_handle, priority_req
	input  logic [spq_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // func
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [spq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata   // accepted, popped_handle,
	                                                        // entry_count, queue_empty
);
	import spq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTH
	// a taken transfer keeps the input closed until its result is out
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready while an operation is in flight");

	// a nonzero handle comes out only from a successful pop
	a_handle_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[32:1] != '0) |-> m_axis_tdata[0])
		else $error("popped handle without accepted");

	// empty flag and entry count agree
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[39] |-> (m_axis_tdata[38:33] == '0))
		else $error("queue_empty with nonzero entry_count");

	// the controller never stores into a full queue
	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.full)
		else $error("insert into a full queue");
`endif

endmodule
